// File: hw/rtl/point_cloud_axis_histogram_defines.svh
// assertion macros for the point cloud axis histogram
// used by the top level; no other dependencies
`ifndef POINT_CLOUD_AXIS_HISTOGRAM_DEFINES_SVH
`define POINT_CLOUD_AXIS_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define PCAH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PCAH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PCAH_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PCAH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/pcah_pkg.sv
// shared types and constants for the point cloud axis histogram
// no dependencies
`timescale 1ns / 1ps
package pcah_pkg;

   localparam int COORD_W = 16;
   localparam int COUNT_W = 20;
   localparam int BIN_W = 6;
   localparam int STORE_W = 3 * COORD_W + 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP = 20'hFFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -16'sh8000;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic point_valid;
      logic frame_end;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0] bin_number;
      logic [COUNT_W-1:0] count_x;
      logic [COUNT_W-1:0] count_y;
      logic [COUNT_W-1:0] count_z;
      logic [COUNT_W-1:0] peak_z;
      logic points_dropped;
      logic last_bin;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic ctr_clr;
      logic clear_wr;
      logic fetch;
      logic div_load;
      logic div_step;
      logic cnt_rd;
      logic cnt_wr;
      logic emit_rd;
      logic frame_done;
   } cmd_type;

   typedef struct packed {
      logic ctr_last;
      logic idx_last;
      logic store_empty;
      logic div_last;
   } status_type;

endpackage

// File: hw/rtl/pcah_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module pcah_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/pcah_ctrl.sv
// sequencer for load, clear, binning and result passes
// depends on pcah_pkg
`timescale 1ns / 1ps
module pcah_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                frame_end,
   input  pcah_pkg::status_type status,
   output pcah_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [3:0] {
      S_LOAD, S_CLEAR, S_FETCH, S_DLOAD, S_DIV, S_CRD, S_CWR, S_EMIT, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (start && !busy_ff) begin
               cmd.accept = 1'b1;
               if (frame_end) begin
                  cmd.ctr_clr = 1'b1;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.ctr_last) begin
               cmd.ctr_clr = 1'b1;
               state_in = status.store_empty ? S_EMIT : S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            cmd.cnt_rd = 1'b1;
            state_in = S_CWR;
         end
         S_CWR: begin
            cmd.cnt_wr = 1'b1;
            if (status.idx_last) begin
               cmd.ctr_clr = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_EMIT: begin
            cmd.emit_rd = 1'b1;
            if (status.ctr_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.frame_done = 1'b1;
            state_in = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= (state_in != S_LOAD);
      end
   end

   assign busy = busy_ff;

endmodule

// File: hw/rtl/pcah_dp.sv
// datapath: point buffer, min/max tracking, bin divider, count memories
// depends on pcah_pkg and pcah_ram
`timescale 1ns / 1ps
module pcah_dp #(
   parameter int BINS = 64,
   parameter int MAX_POINTS = 524288
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcah_pkg::cmd_type    cmd,
   input  pcah_pkg::req_type    req,
   output pcah_pkg::status_type status,
   output logic                 rsp_strobe,
   output pcah_pkg::rsp_type    rsp
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int SCW = AW + 1;
   localparam int BAW = $clog2(BINS);
   localparam int QW = BAW + 1;
   localparam int SW = (QW > 1) ? $clog2(QW) : 1;
   localparam int NW = pcah_pkg::COORD_W + $clog2(2 * BINS) + 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int CW_W = pcah_pkg::COORD_W;
   localparam logic [NW-1:0] BSCALE = NW'(2 * BINS);

   // load side
   logic [SCW-1:0] count_ff;
   logic signed [CW_W-1:0] min_ff [3];
   logic signed [CW_W-1:0] max_ff [3];
   logic overflow_ff;
   logic full;
   logic signed [CW_W-1:0] pin [3];

   // store
   logic store_we;
   logic [pcah_pkg::STORE_W-1:0] store_rdata;
   logic [AW-1:0] idx_ff;

   // binning
   logic [CW_W-1:0] span_ff;
   logic signed [CW_W-1:0] gmax, gmin;
   logic [NW-1:0] rem_ff [3];
   logic [QW-1:0] q_ff [3];
   logic [NW-1:0] dsh_ff;
   logic [SW-1:0] step_ff;
   logic pvalid_ff;
   logic [BAW-1:0] ctr_ff;
   logic [CW-1:0] peak_ff;
   logic emit_ff;
   logic [BAW-1:0] emit_bin_ff;

   logic [BAW-1:0] bin [3];
   logic inr [3];
   logic [BAW-1:0] craddr [3];
   logic [BAW-1:0] cwaddr [3];
   logic [CW-1:0] cwdata [3];
   logic [CW-1:0] crdata [3];
   logic [CW-1:0] cinc [3];
   logic cwe [3];

   assign pin[0] = req.pos_x;
   assign pin[1] = req.pos_y;
   assign pin[2] = req.pos_z;
   assign full = (count_ff == SCW'(MAX_POINTS));
   assign store_we = cmd.accept && !full;

   pcah_ram #(.WIDTH(pcah_pkg::STORE_W), .DEPTH(MAX_POINTS)) u_store (
      .clock(clock),
      .we(store_we),
      .waddr(count_ff[AW-1:0]),
      .wdata({req.point_valid, req.pos_x, req.pos_y, req.pos_z}),
      .raddr(idx_ff),
      .rdata(store_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.frame_done) begin
         count_ff <= '0;
         overflow_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= pcah_pkg::COORD_MAX;
            max_ff[a] <= pcah_pkg::COORD_MIN;
         end
      end else if (cmd.accept) begin
         if (full) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + SCW'(1);
            if (req.point_valid) begin
               for (int a = 0; a < 3; a++) begin
                  if (pin[a] < min_ff[a]) min_ff[a] <= pin[a];
                  if (pin[a] > max_ff[a]) max_ff[a] <= pin[a];
               end
            end
         end
      end
   end

   // global span over all three axes
   always_comb begin
      gmax = max_ff[0];
      gmin = min_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (max_ff[a] > gmax) gmax = max_ff[a];
         if (min_ff[a] < gmin) gmin = min_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         span_ff <= (gmax > gmin) ? CW_W'(gmax - gmin) : '0;
      end
   end

   // bin index per axis, restoring divide one quotient bit a cycle
   always_ff @(posedge clock) begin
      logic signed [CW_W:0] off;
      logic signed [CW_W-1:0] v;
      if (cmd.div_load) begin
         pvalid_ff <= store_rdata[pcah_pkg::STORE_W-1];
         dsh_ff <= NW'({span_ff, 1'b0}) << BAW;
         step_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            v = store_rdata[(2-a)*CW_W +: CW_W];
            off = {v[CW_W-1], v} - {min_ff[a][CW_W-1], min_ff[a]};
            rem_ff[a] <= NW'(off[CW_W-1:0]) * BSCALE + NW'(span_ff);
            q_ff[a] <= '0;
         end
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         step_ff <= step_ff + SW'(1);
         for (int a = 0; a < 3; a++) begin
            if (rem_ff[a] >= dsh_ff) begin
               rem_ff[a] <= rem_ff[a] - dsh_ff;
               q_ff[a] <= {q_ff[a][QW-2:0], 1'b1};
            end else begin
               q_ff[a] <= {q_ff[a][QW-2:0], 1'b0};
            end
         end
      end
   end

   // zero span puts every point in bin 0
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         bin[a] = (span_ff == '0) ? '0 : q_ff[a][BAW-1:0];
         inr[a] = (span_ff == '0) || (q_ff[a] < QW'(BINS));
         cinc[a] = crdata[a] + CW'(1);
         craddr[a] = cmd.emit_rd ? ctr_ff : bin[a];
         cwaddr[a] = cmd.clear_wr ? ctr_ff : bin[a];
         cwdata[a] = cmd.clear_wr ? '0 : cinc[a];
         cwe[a] = cmd.clear_wr || (cmd.cnt_wr && pvalid_ff && inr[a]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_cnt
      pcah_ram #(.WIDTH(CW), .DEPTH(BINS)) u_cnt (
         .clock(clock),
         .we(cwe[g]),
         .waddr(cwaddr[g]),
         .wdata(cwdata[g]),
         .raddr(craddr[g]),
         .rdata(crdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         idx_ff <= '0;
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= cmd.emit_rd;
         if (cmd.ctr_clr) begin
            ctr_ff <= '0;
            idx_ff <= '0;
         end else begin
            if (cmd.clear_wr || cmd.emit_rd) ctr_ff <= ctr_ff + BAW'(1);
            if (cmd.cnt_wr) idx_ff <= idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_rd) emit_bin_ff <= ctr_ff;
      if (cmd.clear_wr) begin
         peak_ff <= '0;
      end else if (cwe[2] && cmd.cnt_wr && (cinc[2] > peak_ff)) begin
         peak_ff <= cinc[2];
      end
   end

   function automatic logic [pcah_pkg::COUNT_W-1:0] cap_count(input logic [CW-1:0] c);
      logic [31:0] e;
      e = 32'(c);
      return (e > 32'(pcah_pkg::COUNT_CAP)) ? pcah_pkg::COUNT_CAP
                                            : e[pcah_pkg::COUNT_W-1:0];
   endfunction

   assign status.ctr_last = (ctr_ff == BAW'(BINS - 1));
   assign status.idx_last = ((SCW'(idx_ff) + SCW'(1)) == count_ff);
   assign status.store_empty = (count_ff == '0);
   assign status.div_last = (step_ff == SW'(QW - 1));

   assign rsp_strobe = emit_ff;
   assign rsp.bin_number = pcah_pkg::BIN_W'(emit_bin_ff);
   assign rsp.count_x = cap_count(crdata[0]);
   assign rsp.count_y = cap_count(crdata[1]);
   assign rsp.count_z = cap_count(crdata[2]);
   assign rsp.peak_z = cap_count(peak_ff);
   assign rsp.points_dropped = overflow_ff;
   assign rsp.last_bin = (emit_bin_ff == BAW'(BINS - 1));

endmodule

// File: hw/rtl/point_cloud_axis_histogram.sv
// Points of a frame are taken one per cycle while busy is low; the point with frame_end
// starts the histogram pass and raises busy from the next cycle. The pass first clears the
// count memories, then runs each stored point, not-a-number points included, through
// buffer read, divider load, log2(BINS)+1 = 7 quotient steps at BINS = 64, count read and
// count write, one point at a time through the shared restoring divider and the
// read-modify-write of the count memories. The BINS results then follow on back-to-back
// cycles, one per rsp_strobe; the receiver cannot stall them, and busy falls in the cycle
// after the last result.
// top level: controller, datapath; depends on pcah_pkg, pcah_ctrl, pcah_dp
`timescale 1ns / 1ps
`include "point_cloud_axis_histogram_defines.svh"
module point_cloud_axis_histogram #(
   parameter int BINS = 64,
   parameter int MAX_POINTS = 524288
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pcah_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pcah_pkg::rsp_type rsp_data
);

   pcah_pkg::cmd_type cmd;
   pcah_pkg::status_type status;

   pcah_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .frame_end(req_data.frame_end),
      .status(status),
      .cmd(cmd),
      .busy(busy)
   );

   pcah_dp #(.BINS(BINS), .MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req(req_data),
      .status(status),
      .rsp_strobe(rsp_strobe),
      .rsp(rsp_data)
   );

   `PCAH_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_strobe, busy)
   `PCAH_ASSERT_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_data.last_bin, !rsp_strobe)
   `PCAH_ASSERT_NEXT(a_frame_end_busy, clock, reset, start && !busy && req_data.frame_end, busy)

endmodule
